// ===== design/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants of the lexical shortlist selector.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam logic [1:0] ACT_LOAD_OFF  = 2'd0;
  localparam logic [1:0] ACT_LOAD_LIST = 2'd1;
  localparam logic [1:0] ACT_WORD      = 2'd2;
  localparam logic [1:0] ACT_FINISH    = 2'd3;

  localparam logic [2:0] CFG_FREQ_COUNT = 3'd0;
  localparam logic [2:0] CFG_MIN_CAND   = 3'd1;
  localparam logic [2:0] CFG_SHARED     = 3'd2;
  localparam logic [2:0] CFG_SRC_SIZE   = 3'd3;
  localparam logic [2:0] CFG_TGT_SIZE   = 3'd4;

  // seen-tag width; epoch zero marks a cleared entry
  localparam int EPOCH_W = 8;
  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] table_index;
    logic [16:0] table_value;
    logic [14:0] word;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  segment;
    logic [63:0] mask;
    logic [12:0] selected_count;
    logic        bad_word;
    logic        last_segment;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_LOAD_OFF,
    CMD_LOAD_LIST,
    CMD_WORD,
    CMD_FINISH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        bad;
    logic [15:0] index;
    logic [16:0] value;
    logic [14:0] word;
    logic        last;
  } cmd_t;

  // clamped configuration as the engine uses it
  typedef struct packed {
    logic [12:0] freq_count;
    logic [12:0] min_cand;
    logic        shared;
    logic [15:0] src_size;
    logic [12:0] tgt_size;
  } cfg_t;

endpackage

// ===== design/lexical_shortlist_selector.sv =====
// ----------------------------------------------------------------------------
// lexical_shortlist_selector
// Builds a target-vocabulary shortlist from source words, emitted as bitmaps.
// ----------------------------------------------------------------------------
// Usage: input beats carry load-offset, load-list, source-word or finish
// actions (valid/stall). A source word with last set, or a finish, triggers
// the emission: one output beat per 64-id slice of the target vocabulary,
// ceil(target size in use / 64) beats, the final one flagged last_segment.
// Engine: loads are written as the engine pops them. A word out of range is
// flagged and selects nothing; otherwise shared mode may select its own id,
// and a word not yet seen in the sentence walks its list entries (a bad id
// flags bad_word). The first word or finish of a sentence first runs the
// frequent fill, row by row. Emission runs the top-up walk the same way,
// then presents the segments and clears. The bitmap memory port (read, then
// write) bounds all of this. A 4-deep command queue sits between the input
// and the engine.
// Reset: control clears; the engine then sweeps all SOURCE_VOCAB entries of
// the seen-word tag memory before taking commands, and repeats that sweep
// after every 255th emission. cfg_ready is tied high; write configuration
// only while no command is in flight.
// A stalled output holds its beat; the engine keeps working until it has a
// further beat to present.
module lexical_shortlist_selector #(
  parameter int SOURCE_VOCAB = 32768,
  parameter int TARGET_VOCAB = 4096,
  parameter int LIST_DEPTH   = 65536,
  parameter int ALIGN        = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lss_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [12:0] freq_r, minc_r, tgt_r;
  logic        shared_r;
  logic [15:0] src_r;
  lss_pkg::cfg_t cfg;
  logic [16:0] src_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r   <= '0;
      minc_r   <= '0;
      shared_r <= 1'b0;
      src_r    <= 16'd32768;
      tgt_r    <= 13'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lss_pkg::CFG_FREQ_COUNT: freq_r   <= cfg_data[12:0];
        lss_pkg::CFG_MIN_CAND:   minc_r   <= cfg_data[12:0];
        lss_pkg::CFG_SHARED:     shared_r <= cfg_data[0];
        lss_pkg::CFG_SRC_SIZE:   src_r    <= cfg_data;
        lss_pkg::CFG_TGT_SIZE:   tgt_r    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // sizes clamped to [1, vocab]
  assign src_ext = {1'b0, src_r};
  always_comb begin
    cfg.freq_count = freq_r;
    cfg.min_cand   = minc_r;
    cfg.shared     = shared_r;
    if (src_r == '0) cfg.src_size = 16'd1;
    else if (src_ext > 17'(SOURCE_VOCAB)) cfg.src_size = 16'(SOURCE_VOCAB);
    else cfg.src_size = src_r;
    if (tgt_r == '0) cfg.tgt_size = 13'd1;
    else if (tgt_r > 13'(TARGET_VOCAB)) cfg.tgt_size = 13'(TARGET_VOCAB);
    else cfg.tgt_size = tgt_r;
  end

  logic          q_full, q_push, q_pop, q_valid;
  lss_pkg::cmd_t q_in, q_out;

  lss_front #(
    .SOURCE_VOCAB(SOURCE_VOCAB),
    .TARGET_VOCAB(TARGET_VOCAB),
    .LIST_DEPTH  (LIST_DEPTH)
  ) u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_in)
  );

  lss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_data (q_out)
  );

  lss_back #(
    .SOURCE_VOCAB(SOURCE_VOCAB),
    .TARGET_VOCAB(TARGET_VOCAB),
    .LIST_DEPTH  (LIST_DEPTH),
    .ALIGN       (ALIGN)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_cmd    (q_out),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== design/lss_front.sv =====
// ----------------------------------------------------------------------------
// lss_front
// Accepts input beats, range-checks them and turns them into commands.
// ----------------------------------------------------------------------------
module lss_front #(
  parameter int SOURCE_VOCAB = 32768,
  parameter int TARGET_VOCAB = 4096,
  parameter int LIST_DEPTH   = 65536
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  lss_pkg::in_item_t in_data,
  input  lss_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              q_push,
  output lss_pkg::cmd_t     q_cmd
);

  localparam logic [16:0] OFF_LIM  = 17'(SOURCE_VOCAB);
  localparam logic [20:0] LIST_LIM = 21'(LIST_DEPTH);
  localparam logic [16:0] TGT_LIM  = 17'(TARGET_VOCAB);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd       = '0;
    q_cmd.index = in_data.table_index;
    q_cmd.value = in_data.table_value;
    q_cmd.word  = in_data.word;
    q_cmd.last  = in_data.last;
    unique case (in_data.action)
      lss_pkg::ACT_LOAD_OFF: begin
        q_cmd.kind = lss_pkg::CMD_LOAD_OFF;
        q_cmd.bad  = {1'b0, in_data.table_index} > OFF_LIM;
      end
      lss_pkg::ACT_LOAD_LIST: begin
        q_cmd.kind = lss_pkg::CMD_LOAD_LIST;
        q_cmd.bad  = ({5'b0, in_data.table_index} >= LIST_LIM) ||
                     (in_data.table_value >= TGT_LIM);
      end
      lss_pkg::ACT_WORD: begin
        q_cmd.kind = lss_pkg::CMD_WORD;
        q_cmd.bad  = {1'b0, in_data.word} >= cfg.src_size;
      end
      default: begin
        q_cmd.kind = lss_pkg::CMD_FINISH;
        q_cmd.bad  = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/lss_queue.sv =====
// ----------------------------------------------------------------------------
// lss_queue
// Small command FIFO between the front and the engine.
// ----------------------------------------------------------------------------
module lss_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lss_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output lss_pkg::cmd_t pop_data
);

  localparam int PW = $clog2(lss_pkg::Q_DEPTH);

  lss_pkg::cmd_t   fifo_r [lss_pkg::Q_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign full      = cnt_r == (PW+1)'(lss_pkg::Q_DEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_data  = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== design/lss_back.sv =====
// ----------------------------------------------------------------------------
// lss_back
// Selection engine: table memories, seen tags, target bitmap and emission.
// ----------------------------------------------------------------------------
module lss_back #(
  parameter int SOURCE_VOCAB = 32768,
  parameter int TARGET_VOCAB = 4096,
  parameter int LIST_DEPTH   = 65536,
  parameter int ALIGN        = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lss_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  lss_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lss_pkg::out_item_t out_data
);

  localparam int OAW   = $clog2(SOURCE_VOCAB + 1);
  localparam int SAW   = $clog2(SOURCE_VOCAB);
  localparam int LMEM  = (LIST_DEPTH < 65536) ? LIST_DEPTH : 65536;
  localparam int LAW   = (LMEM > 1) ? $clog2(LMEM) : 1;
  localparam int TID_W = $clog2(TARGET_VOCAB);
  localparam int ROWS  = (TARGET_VOCAB + 63) / 64;
  localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int MW    = (ALIGN > 1) ? $clog2(ALIGN) : 1;
  localparam int EPOCH_WL = lss_pkg::EPOCH_W;
  localparam logic [MW-1:0]  MOD_TOP  = MW'(ALIGN - 1);
  localparam logic [20:0]    LIST_LIM = 21'(LIST_DEPTH);
  localparam logic [SAW-1:0] CLR_END  = SAW'(SOURCE_VOCAB - 1);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_WK_RD, ST_WK_LD, ST_WK_STEP, ST_TOPUP,
    ST_W_CHK, ST_W_SEEN, ST_W_TAG, ST_W_OFF1, ST_W_OFF2, ST_L_RD, ST_L_Q,
    ST_S_RD, ST_S_WR, ST_W_END, ST_E_RD, ST_E_OUT, ST_E_CLR
  } state_t;

  // memories
  logic [16:0]        off_mem  [SOURCE_VOCAB + 1];
  logic [TID_W-1:0]   list_mem [LMEM];
  logic [EPOCH_WL-1:0] seen_mem [SOURCE_VOCAB];
  logic [63:0]        bm_mem   [ROWS];

  logic               off_we;
  logic [OAW-1:0]     off_waddr, off_raddr;
  logic [16:0]        off_q;
  logic               list_we;
  logic [LAW-1:0]     list_waddr, list_raddr;
  logic [TID_W-1:0]   list_q;
  logic               seen_we;
  logic [SAW-1:0]     seen_waddr, seen_raddr;
  logic [EPOCH_WL-1:0] seen_wdata, seen_q;
  logic               bm_we;
  logic [RAW-1:0]     bm_waddr, bm_raddr;
  logic [63:0]        bm_wdata, bm_q;
  logic               bm_vld_q;
  logic [16:0]        cmd_value_w;

  assign cmd_value_w = q_cmd.value;

  always_ff @(posedge clk) begin
    if (off_we) off_mem[off_waddr] <= cmd_value_w;
    off_q <= off_mem[off_raddr];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_waddr] <= cmd_value_w[TID_W-1:0];
    list_q <= list_mem[list_raddr];
  end

  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[seen_waddr] <= seen_wdata;
    seen_q <= seen_mem[seen_raddr];
  end

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    bm_q <= bm_mem[bm_raddr];
  end

  // state
  state_t              state_r, state_nxt, ret_r, ret_nxt;
  lss_pkg::cmd_t       cmd_r, cmd_nxt;
  logic                freq_done_r, freq_done_nxt;
  logic                err_r, err_nxt;
  logic [12:0]         total_r, total_nxt;
  logic [MW-1:0]       mod_r, mod_nxt;
  logic [EPOCH_WL-1:0] epoch_r, epoch_nxt;
  logic [SAW-1:0]      clr_r, clr_nxt;
  logic [12:0]         wi_r, wi_nxt;
  logic                wfreq_r, wfreq_nxt;
  logic [63:0]         row_r, row_nxt;
  logic [12:0]         id_r, id_nxt;
  logic [16:0]         j_r, j_nxt, end_r, end_nxt;
  logic [5:0]          seg_r, seg_nxt;
  logic [ROWS-1:0]     rvld_r, rvld_nxt;
  logic                out_valid_r, out_valid_nxt;
  lss_pkg::out_item_t  out_r, out_nxt;

  logic [12:0] tsz, nfreq, tm1;
  logic        wk_cond;
  logic [16:0] wx;
  logic [63:0] cur_row, bitv;
  logic        out_free;

  assign tsz      = cfg.tgt_size;
  assign nfreq    = (cfg.freq_count < tsz) ? cfg.freq_count : tsz;
  assign tm1      = tsz - 13'd1;
  assign wx       = {2'b0, cmd_r.word};
  assign out_free = !out_valid_r || !out_stall;
  assign wk_cond  = wfreq_r ? (wi_r < nfreq)
                            : ((wi_r < tsz) && ((total_r < cfg.min_cand) || (mod_r != '0)));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cmd_nxt       = cmd_r;
    freq_done_nxt = freq_done_r;
    err_nxt       = err_r;
    total_nxt     = total_r;
    mod_nxt       = mod_r;
    epoch_nxt     = epoch_r;
    clr_nxt       = clr_r;
    wi_nxt        = wi_r;
    wfreq_nxt     = wfreq_r;
    row_nxt       = row_r;
    id_nxt        = id_r;
    j_nxt         = j_r;
    end_nxt       = end_r;
    seg_nxt       = seg_r;
    rvld_nxt      = rvld_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    off_we        = 1'b0;
    off_waddr     = OAW'({1'b0, q_cmd.index});
    off_raddr     = wx[OAW-1:0];
    list_we       = 1'b0;
    list_waddr    = q_cmd.index[LAW-1:0];
    list_raddr    = j_r[LAW-1:0];
    seen_we       = 1'b0;
    seen_waddr    = wx[SAW-1:0];
    seen_raddr    = wx[SAW-1:0];
    seen_wdata    = epoch_r;
    bm_we         = 1'b0;
    bm_waddr      = wi_r[6 +: RAW];
    bm_raddr      = wi_r[6 +: RAW];
    bm_wdata      = row_r;
    cur_row       = bm_vld_q ? bm_q : 64'd0;
    bitv          = 64'd1 << id_r[5:0];

    unique case (state_r)
      ST_CLR: begin
        seen_we    = 1'b1;
        seen_waddr = clr_r;
        seen_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == CLR_END) begin
          epoch_nxt = EPOCH_WL'(1);
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          unique case (q_cmd.kind)
            lss_pkg::CMD_LOAD_OFF: begin
              if (q_cmd.bad) err_nxt = 1'b1;
              else off_we = 1'b1;
            end
            lss_pkg::CMD_LOAD_LIST: begin
              if (q_cmd.bad) err_nxt = 1'b1;
              else list_we = 1'b1;
            end
            lss_pkg::CMD_WORD, lss_pkg::CMD_FINISH: begin
              if (!freq_done_r) begin
                freq_done_nxt = 1'b1;
                wi_nxt        = '0;
                wfreq_nxt     = 1'b1;
                ret_nxt       = (q_cmd.kind == lss_pkg::CMD_WORD) ? ST_W_CHK : ST_TOPUP;
                state_nxt     = ST_WK_RD;
              end else begin
                state_nxt = (q_cmd.kind == lss_pkg::CMD_WORD) ? ST_W_CHK : ST_TOPUP;
              end
            end
            default: ;
          endcase
        end
      end
      // row walker: frequent fill or top-up, one id per cycle within a row
      ST_WK_RD: begin
        state_nxt = wk_cond ? ST_WK_LD : ret_r;
      end
      ST_WK_LD: begin
        row_nxt   = cur_row;
        state_nxt = ST_WK_STEP;
      end
      ST_WK_STEP: begin
        bm_wdata = row_r;
        if (wk_cond) begin
          if (!row_r[wi_r[5:0]]) begin
            bm_wdata  = row_r | (64'd1 << wi_r[5:0]);
            total_nxt = total_r + 13'd1;
            mod_nxt   = (mod_r == MOD_TOP) ? '0 : mod_r + 1'b1;
          end
          row_nxt = bm_wdata;
          wi_nxt  = wi_r + 13'd1;
        end
        if (!wk_cond || (wi_r[5:0] == 6'd63)) begin
          bm_we                      = 1'b1;
          rvld_nxt[wi_r[6 +: RAW]]   = 1'b1;
          state_nxt                  = wk_cond ? ST_WK_RD : ret_r;
        end
      end
      ST_TOPUP: begin
        wi_nxt    = cfg.freq_count;
        wfreq_nxt = 1'b0;
        ret_nxt   = ST_E_RD;
        seg_nxt   = '0;
        state_nxt = ST_WK_RD;
      end
      ST_W_CHK: begin
        if (cmd_r.bad) begin
          err_nxt   = 1'b1;
          state_nxt = ST_W_END;
        end else if (cfg.shared) begin
          if ({2'b0, tsz} > cmd_r.word) begin
            id_nxt    = cmd_r.word[12:0];
            ret_nxt   = ST_W_SEEN;
            state_nxt = ST_S_RD;
          end else begin
            err_nxt   = 1'b1;
            state_nxt = ST_W_SEEN;
          end
        end else begin
          state_nxt = ST_W_SEEN;
        end
      end
      ST_W_SEEN: begin
        state_nxt = ST_W_TAG;
      end
      ST_W_TAG: begin
        if (seen_q == epoch_r) begin
          state_nxt = ST_W_END;
        end else begin
          seen_we   = 1'b1;
          state_nxt = ST_W_OFF1;
        end
      end
      ST_W_OFF1: begin
        off_raddr = OAW'(wx + 17'd1);
        j_nxt     = off_q;
        state_nxt = ST_W_OFF2;
      end
      ST_W_OFF2: begin
        if ({4'b0, off_q} > LIST_LIM) begin
          end_nxt = LIST_LIM[16:0];
          err_nxt = 1'b1;
        end else begin
          end_nxt = off_q;
        end
        state_nxt = ST_L_RD;
      end
      ST_L_RD: begin
        state_nxt = (j_r < end_r) ? ST_L_Q : ST_W_END;
      end
      ST_L_Q: begin
        j_nxt = j_r + 17'd1;
        if (13'(list_q) < tsz) begin
          id_nxt    = 13'(list_q);
          ret_nxt   = ST_L_RD;
          state_nxt = ST_S_RD;
        end else begin
          err_nxt   = 1'b1;
          state_nxt = ST_L_RD;
        end
      end
      ST_S_RD: begin
        bm_raddr  = id_r[6 +: RAW];
        state_nxt = ST_S_WR;
      end
      ST_S_WR: begin
        bm_waddr = id_r[6 +: RAW];
        bm_wdata = cur_row | bitv;
        bm_we    = 1'b1;
        rvld_nxt[id_r[6 +: RAW]] = 1'b1;
        if ((cur_row & bitv) == 64'd0) begin
          total_nxt = total_r + 13'd1;
          mod_nxt   = (mod_r == MOD_TOP) ? '0 : mod_r + 1'b1;
        end
        state_nxt = ret_r;
      end
      ST_W_END: begin
        state_nxt = cmd_r.last ? ST_TOPUP : ST_IDLE;
      end
      ST_E_RD: begin
        bm_raddr  = seg_r[RAW-1:0];
        state_nxt = ST_E_OUT;
      end
      ST_E_OUT: begin
        bm_raddr = seg_r[RAW-1:0];
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.segment        = seg_r;
          out_nxt.mask           = ((seg_r == tm1[11:6]) && (tsz[5:0] != 6'd0))
                                   ? (cur_row & ~({64{1'b1}} << tsz[5:0])) : cur_row;
          out_nxt.selected_count = total_r;
          out_nxt.bad_word       = err_r;
          out_nxt.last_segment   = seg_r == tm1[11:6];
          if (seg_r == tm1[11:6]) begin
            state_nxt = ST_E_CLR;
          end else begin
            seg_nxt   = seg_r + 6'd1;
            state_nxt = ST_E_RD;
          end
        end
      end
      ST_E_CLR: begin
        rvld_nxt      = '0;
        total_nxt     = '0;
        mod_nxt       = '0;
        err_nxt       = 1'b0;
        freq_done_nxt = 1'b0;
        seg_nxt       = '0;
        epoch_nxt     = epoch_r + 1'b1;
        if (epoch_nxt == '0) begin
          clr_nxt   = '0;
          state_nxt = ST_CLR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    bm_vld_q <= rvld_r[bm_raddr];
    cmd_r    <= cmd_nxt;
    row_r    <= row_nxt;
    id_r     <= id_nxt;
    j_r      <= j_nxt;
    end_r    <= end_nxt;
    wi_r     <= wi_nxt;
    wfreq_r  <= wfreq_nxt;
    ret_r    <= ret_nxt;
    out_r    <= out_nxt;
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      epoch_r     <= EPOCH_WL'(1);
      freq_done_r <= 1'b0;
      err_r       <= 1'b0;
      total_r     <= '0;
      mod_r       <= '0;
      seg_r       <= '0;
      rvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      epoch_r     <= epoch_nxt;
      freq_done_r <= freq_done_nxt;
      err_r       <= err_nxt;
      total_r     <= total_nxt;
      mod_r       <= mod_nxt;
      seg_r       <= seg_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/lss_checker.sv =====
// ----------------------------------------------------------------------------
// lss_checker
// Port-level checks on the emitted segment stream.
// ----------------------------------------------------------------------------
module lss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input lss_pkg::out_item_t out_data
);

  logic [5:0]  exp_seg_r;
  logic [12:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seg_r <= '0;
      cnt_r     <= '0;
    end else if (out_valid && !out_stall) begin
      exp_seg_r <= out_data.last_segment ? 6'd0 : out_data.segment + 6'd1;
      cnt_r     <= out_data.selected_count;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_seg_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.segment == exp_seg_r)
    else $error("segments out of order");

  a_count_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && exp_seg_r != 6'd0 |-> out_data.selected_count == cnt_r)
    else $error("selected count changed within an emission");

  a_top_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.segment == 6'd63 |-> out_data.last_segment)
    else $error("segment 63 not flagged last");

endmodule

bind lexical_shortlist_selector lss_checker u_lss_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
